@@ sv/swm_pkg.sv @@
`default_nettype none

package swm_pkg;

	localparam int FIELD_W          = 16;
	localparam int CFG_W            = 7;
	localparam int DEF_MAX_WINDOW   = 64;
	localparam int DEF_SAMPLE_WIDTH = 16;

	localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 7'd3;

	typedef struct packed {
		logic start;
		logic step;
		logic finish;
		logic load_out;
	} swm_cmd_t;

	typedef struct packed {
		logic empty_pass;
		logic last_in;
		logic result;
	} swm_status_t;

endpackage

`default_nettype wire

@@ sv/sliding_window_median_unit.sv @@
// Running median filter: each transfer on the input channel brings one unsigned sample; once
// window_len samples are held, every input gives one output transfer carrying the median of the
// last window_len (at most MAX_WINDOW) samples (the lower middle value for an even length, the
// sample itself for a length of one or zero). A write to window_len empties the window. The
// samples are kept in an arrival ring and a sorted store, each a memory with one read and one
// write port; each item makes one merge pass over the sorted store, one entry per cycle, that
// removes the sample leaving the window and inserts the new one. The input is stalled while an
// item is in the merge-pass and last-entry states, and also for as long as a finished result
// waits for the previous one to leave the output register.
`default_nettype none

module sliding_window_median_unit #(
	parameter int MAX_WINDOW   = swm_pkg::DEF_MAX_WINDOW,
	parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire [swm_pkg::FIELD_W-1:0]  sample,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [swm_pkg::FIELD_W-1:0] median,
	input  wire                         window_len_we,
	input  wire [swm_pkg::CFG_W-1:0]    window_len
);
	import swm_pkg::*;

	swm_cmd_t    cmd;
	swm_status_t status;

	swm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	swm_dpath #(
		.MAX_WINDOW   (MAX_WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sample        (sample),
		.window_len_we (window_len_we),
		.window_len    (window_len),
		.status        (status),
		.median        (median)
	);

endmodule

`default_nettype wire

@@ sv/swm_ctrl.sv @@
`default_nettype none

module swm_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  wire                  out_stall,
	input  swm_pkg::swm_status_t status,
	output swm_pkg::swm_cmd_t    cmd,
	output logic                 in_stall,
	output logic                 out_valid
);
	import swm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PASS = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_nxt = status.empty_pass ? ST_LAST : ST_PASS;
				end
			end
			ST_PASS: begin
				cmd.step = 1'b1;
				if (status.last_in) begin
					state_nxt = ST_LAST;
				end
			end
			ST_LAST: begin
				cmd.finish = 1'b1;
				state_nxt  = status.result ? ST_OUT : ST_IDLE;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (state_q == ST_OUT))
		else $error("result loaded outside output state");

	a_out_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && out_free |=> (state_q == ST_IDLE) && out_valid_q)
		else $error("output state did not hand over result");

	a_pass_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start && !status.empty_pass |=> (state_q == ST_PASS))
		else $error("merge pass not entered after transfer");

endmodule

`default_nettype wire

@@ sv/swm_dpath.sv @@
`default_nettype none

module swm_dpath #(
	parameter int MAX_WINDOW   = swm_pkg::DEF_MAX_WINDOW,
	parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  swm_pkg::swm_cmd_t           cmd,
	input  wire [swm_pkg::FIELD_W-1:0]  sample,
	input  wire                         window_len_we,
	input  wire [swm_pkg::CFG_W-1:0]    window_len,
	output swm_pkg::swm_status_t        status,
	output logic [swm_pkg::FIELD_W-1:0] median
);
	import swm_pkg::*;

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LW = $clog2(MAX_WINDOW + 1);
	localparam int DW = (SAMPLE_WIDTH < FIELD_W) ? SAMPLE_WIDTH : FIELD_W;

	logic [DW-1:0] ring_mem   [MAX_WINDOW];
	logic [DW-1:0] sorted_mem [MAX_WINDOW];

	logic [CFG_W-1:0] wlen_q;
	logic [LW-1:0]    fill_q;
	logic [AW-1:0]    oldest_q;
	logic [DW-1:0]    old_q;
	logic [DW-1:0]    srd_q;
	logic [DW-1:0]    buf_q;
	logic [DW-1:0]    med_q;
	logic [DW-1:0]    out_q;
	logic [LW-1:0]    n_q;
	logic [LW-1:0]    j_q;
	logic [LW-1:0]    w_q;
	logic             skipped_q;
	logic             full_pass_q;
	logic             res_q;

	logic [LW-1:0] len;
	logic [LW-1:0] mid;
	logic          full;
	logic [LW-1:0] n_nxt;
	logic [LW-1:0] j_nxt;
	logic [LW-1:0] fill_inc;
	logic [AW-1:0] oldest_inc;
	logic [AW-1:0] ring_addr;
	logic [DW-1:0] s_in;
	logic          skip;
	logic [DW-1:0] emit_v;
	logic [DW-1:0] keep_v;
	logic          s_re;
	logic          s_we;
	logic [AW-1:0] s_raddr;
	logic [DW-1:0] s_wdata;

	always_comb begin
		if (wlen_q == '0) begin
			len = LW'(1);
		end else if (32'(wlen_q) > 32'(MAX_WINDOW)) begin
			len = LW'(MAX_WINDOW);
		end else begin
			len = LW'(wlen_q);
		end
	end

	assign mid        = (len - LW'(1)) >> 1;
	assign full       = (fill_q >= len);
	assign n_nxt      = full ? len : fill_q;
	assign j_nxt      = j_q + LW'(1);
	assign fill_inc   = fill_q + LW'(1);
	assign oldest_inc = oldest_q + AW'(1);
	assign ring_addr  = full ? oldest_q : fill_q[AW-1:0];
	assign s_in       = DW'(sample);

	assign skip   = full_pass_q && !skipped_q && (srd_q == old_q);
	assign emit_v = (buf_q < srd_q) ? buf_q : srd_q;
	assign keep_v = (buf_q < srd_q) ? srd_q : buf_q;

	assign s_re    = (cmd.start && (n_nxt != '0)) || (cmd.step && (j_nxt < n_q));
	assign s_raddr = cmd.start ? '0 : j_nxt[AW-1:0];
	assign s_we    = (cmd.step && !skip) || cmd.finish;
	assign s_wdata = cmd.finish ? buf_q : emit_v;

	assign status.empty_pass = (n_nxt == '0);
	assign status.last_in    = (j_nxt == n_q);
	assign status.result     = res_q;
	assign median            = FIELD_W'(out_q);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ring_mem[ring_addr] <= s_in;
			if (full) begin
				old_q <= ring_mem[ring_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			sorted_mem[w_q[AW-1:0]] <= s_wdata;
		end
		if (s_re) begin
			srd_q <= sorted_mem[s_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q   <= WINDOW_LEN_RST;
			fill_q   <= '0;
			oldest_q <= '0;
		end else if (window_len_we) begin
			wlen_q   <= window_len;
			fill_q   <= '0;
			oldest_q <= '0;
		end else if (cmd.start) begin
			if (!full) begin
				fill_q <= fill_inc;
			end else if (LW'(oldest_inc) == len || oldest_inc == '0) begin
				oldest_q <= '0;
			end else begin
				oldest_q <= oldest_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			buf_q       <= s_in;
			n_q         <= n_nxt;
			j_q         <= '0;
			w_q         <= '0;
			skipped_q   <= 1'b0;
			full_pass_q <= full;
			res_q       <= full || (fill_inc == len);
		end else if (cmd.step) begin
			j_q <= j_nxt;
			if (skip) begin
				skipped_q <= 1'b1;
			end else begin
				buf_q <= keep_v;
				w_q   <= w_q + LW'(1);
				if (w_q == mid) begin
					med_q <= emit_v;
				end
			end
		end else if (cmd.finish) begin
			if (w_q == mid) begin
				med_q <= buf_q;
			end
		end
		if (cmd.load_out) begin
			out_q <= med_q;
		end
	end

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= len)
		else $error("fill count beyond window length");

	a_write_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (w_q <= j_q))
		else $error("sorted write overtook read");

	a_oldest_while_filling: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> (oldest_q == '0))
		else $error("oldest slot moved before window filled");

endmodule

`default_nettype wire
